// File: rtl/slx_pkg.sv
// Shared types and constants for the shell command lexer.
// Holds the character and token request formats and the queue entry format.
// No dependencies.
package slx_pkg;

	// Token kinds
	localparam logic [3:0] K_SEP    = 4'd0;
	localparam logic [3:0] K_PIPE   = 4'd1;
	localparam logic [3:0] K_LT     = 4'd2;
	localparam logic [3:0] K_GT     = 4'd3;
	localparam logic [3:0] K_APPEND = 4'd4;
	localparam logic [3:0] K_ANDAND = 4'd5;
	localparam logic [3:0] K_BYTE   = 4'd6;
	localparam logic [3:0] K_WEND   = 4'd7;
	localparam logic [3:0] K_DONE   = 4'd8;

	// Characters of interest
	localparam logic [7:0] C_SEMI   = 8'h3B;
	localparam logic [7:0] C_NL     = 8'h0A;
	localparam logic [7:0] C_PIPE   = 8'h7C;
	localparam logic [7:0] C_LT     = 8'h3C;
	localparam logic [7:0] C_GT     = 8'h3E;
	localparam logic [7:0] C_AMP    = 8'h26;
	localparam logic [7:0] C_BSL    = 8'h5C;
	localparam logic [7:0] C_SQUOTE = 8'h27;
	localparam logic [7:0] C_DQUOTE = 8'h22;
	localparam logic [7:0] C_SPACE  = 8'h20;
	localparam logic [7:0] C_TAB    = 8'h09;
	localparam logic [7:0] C_VT     = 8'h0B;
	localparam logic [7:0] C_FF     = 8'h0C;
	localparam logic [7:0] C_CR     = 8'h0D;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_input;
	} char_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  word_byte;
		logic [15:0] token_total;
		logic        last;
	} tok_t;

	// One classified character: up to two results, done total carried along
	typedef struct packed {
		logic [1:0]  count;
		logic [3:0]  kind0;
		logic [7:0]  byte0;
		logic [3:0]  kind1;
		logic [7:0]  byte1;
		logic [15:0] total;
	} entry_t;

endpackage

// File: rtl/slx_front.sv
// Front part of the shell command lexer: accepts characters, tracks the
// lexer mode and token count, and turns each character into a queue entry.
// Depends on slx_pkg.
module slx_front #(
	parameter int COUNT_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  slx_pkg::char_t char_data,
	output logic           push,
	output slx_pkg::entry_t entry
);

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_GT    = 3'd1;
	localparam logic [2:0] M_AMP   = 3'd2;
	localparam logic [2:0] M_BSL   = 3'd3;
	localparam logic [2:0] M_WORD  = 3'd4;
	localparam logic [2:0] M_QUOTE = 3'd5;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	typedef struct packed {
		logic       emit;
		logic [3:0] kind;
		logic [7:0] byte_val;
		logic [2:0] mode;
		logic       set_quote;
		logic       quote_dbl;
	} outside_t;

	logic [2:0]            mode_q;
	logic                  qdbl_q;
	logic [COUNT_BITS-1:0] tokens_q;

	logic [7:0]            c;
	logic                  blank;
	outside_t              oc;
	logic                  pre_emit;
	logic [3:0]            pre_kind;
	logic                  post_emit;
	logic [3:0]            post_kind;
	logic [7:0]            post_byte;
	logic [2:0]            mode_d;
	logic                  qdbl_d;
	logic                  clear;
	logic [COUNT_BITS-1:0] t_pre;
	logic [COUNT_BITS-1:0] t_all;
	logic                  post_counts;

	assign c = char_data.in_char;
	assign blank = (c == slx_pkg::C_SPACE) || (c == slx_pkg::C_TAB) ||
		(c == slx_pkg::C_NL) || (c == slx_pkg::C_VT) ||
		(c == slx_pkg::C_FF) || (c == slx_pkg::C_CR);

	// Classify a character seen outside a word
	always_comb begin
		oc = '0;
		oc.mode = M_IDLE;
		oc.byte_val = 8'h00;
		case (c)
			slx_pkg::C_SEMI, slx_pkg::C_NL: begin
				oc.emit = 1'b1;
				oc.kind = slx_pkg::K_SEP;
			end
			slx_pkg::C_PIPE: begin
				oc.emit = 1'b1;
				oc.kind = slx_pkg::K_PIPE;
			end
			slx_pkg::C_LT: begin
				oc.emit = 1'b1;
				oc.kind = slx_pkg::K_LT;
			end
			slx_pkg::C_GT:  oc.mode = M_GT;
			slx_pkg::C_AMP: oc.mode = M_AMP;
			slx_pkg::C_BSL: oc.mode = M_BSL;
			slx_pkg::C_SQUOTE, slx_pkg::C_DQUOTE: begin
				oc.mode = M_QUOTE;
				oc.set_quote = 1'b1;
				oc.quote_dbl = (c == slx_pkg::C_DQUOTE);
			end
			default: begin
				if (!blank) begin
					oc.emit = 1'b1;
					oc.kind = slx_pkg::K_BYTE;
					oc.byte_val = c;
					oc.mode = M_WORD;
				end
			end
		endcase
	end

	// Next mode and the pair of results for this character
	always_comb begin
		pre_emit = 1'b0;
		pre_kind = slx_pkg::K_SEP;
		post_emit = 1'b0;
		post_kind = slx_pkg::K_SEP;
		post_byte = 8'h00;
		mode_d = mode_q;
		qdbl_d = qdbl_q;
		clear = 1'b0;
		if (char_data.end_of_input) begin
			clear = 1'b1;
			if (mode_q == M_GT) begin
				pre_emit = 1'b1;
				pre_kind = slx_pkg::K_GT;
			end else if (mode_q == M_WORD || mode_q == M_QUOTE) begin
				pre_emit = 1'b1;
				pre_kind = slx_pkg::K_WEND;
			end
			post_emit = 1'b1;
			post_kind = slx_pkg::K_DONE;
		end else begin
			case (mode_q)
				M_GT: begin
					pre_emit = 1'b1;
					if (c == slx_pkg::C_GT) begin
						pre_kind = slx_pkg::K_APPEND;
						mode_d = M_IDLE;
					end else begin
						pre_kind = slx_pkg::K_GT;
						post_emit = oc.emit;
						post_kind = oc.kind;
						post_byte = oc.byte_val;
						mode_d = oc.mode;
						if (oc.set_quote) qdbl_d = oc.quote_dbl;
					end
				end
				M_AMP: begin
					if (c == slx_pkg::C_AMP) begin
						pre_emit = 1'b1;
						pre_kind = slx_pkg::K_ANDAND;
						mode_d = M_IDLE;
					end else begin
						post_emit = oc.emit;
						post_kind = oc.kind;
						post_byte = oc.byte_val;
						mode_d = oc.mode;
						if (oc.set_quote) qdbl_d = oc.quote_dbl;
					end
				end
				M_BSL: begin
					// drop an escaped newline
					if (c == slx_pkg::C_NL) begin
						mode_d = M_IDLE;
					end else begin
						post_emit = oc.emit;
						post_kind = oc.kind;
						post_byte = oc.byte_val;
						mode_d = oc.mode;
						if (oc.set_quote) qdbl_d = oc.quote_dbl;
					end
				end
				M_WORD: begin
					if (blank) begin
						pre_emit = 1'b1;
						pre_kind = slx_pkg::K_WEND;
						post_emit = oc.emit;
						post_kind = oc.kind;
						post_byte = oc.byte_val;
						mode_d = oc.mode;
					end else if (c == slx_pkg::C_SQUOTE || c == slx_pkg::C_DQUOTE) begin
						mode_d = M_QUOTE;
						qdbl_d = (c == slx_pkg::C_DQUOTE);
					end else begin
						post_emit = 1'b1;
						post_kind = slx_pkg::K_BYTE;
						post_byte = c;
					end
				end
				M_QUOTE: begin
					if (c == (qdbl_q ? slx_pkg::C_DQUOTE : slx_pkg::C_SQUOTE)) begin
						mode_d = M_WORD;
					end else begin
						post_emit = 1'b1;
						post_kind = slx_pkg::K_BYTE;
						post_byte = c;
					end
				end
				default: begin
					post_emit = oc.emit;
					post_kind = oc.kind;
					post_byte = oc.byte_val;
					mode_d = oc.mode;
					if (oc.set_quote) qdbl_d = oc.quote_dbl;
				end
			endcase
		end
	end

	// Saturating token count: the pre result always counts when present
	assign post_counts = post_emit && (post_kind != slx_pkg::K_BYTE) &&
		(post_kind != slx_pkg::K_DONE);
	assign t_pre = (pre_emit && tokens_q != CNT_MAX) ? tokens_q + 1'b1 : tokens_q;
	assign t_all = (post_counts && t_pre != CNT_MAX) ? t_pre + 1'b1 : t_pre;

	// Pack the results into one entry
	always_comb begin
		entry = '0;
		entry.total = (32'(t_pre) > 32'h0000_FFFF) ? 16'hFFFF : 16'(t_pre);
		if (pre_emit) begin
			entry.kind0 = pre_kind;
			entry.kind1 = post_kind;
			entry.byte1 = post_byte;
			entry.count = post_emit ? 2'd2 : 2'd1;
		end else begin
			entry.kind0 = post_kind;
			entry.byte0 = post_byte;
			entry.kind1 = slx_pkg::K_SEP;
			entry.count = post_emit ? 2'd1 : 2'd0;
		end
	end

	assign push = accept && (entry.count != 2'd0);

	// Advance lexer state on each accepted character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			qdbl_q <= 1'b0;
			tokens_q <= '0;
		end else if (accept) begin
			if (clear) begin
				mode_q <= M_IDLE;
				qdbl_q <= 1'b0;
				tokens_q <= '0;
			end else begin
				mode_q <= mode_d;
				qdbl_q <= qdbl_d;
				tokens_q <= t_all;
			end
		end
	end

endmodule

// File: rtl/slx_queue.sv
// Short register queue of classified entries between front and back.
// Depends on slx_pkg.
module slx_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  slx_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output slx_pkg::entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	slx_pkg::entry_t slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign full = (fill_q == CW'(DEPTH));
	assign empty = (fill_q == '0);
	assign head = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	// Store the entry at the tail
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_entry;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
		end
	end

endmodule

// File: rtl/slx_back.sv
// Back part of the shell command lexer: walks each queue entry's results
// into a registered token output. Depends on slx_pkg.
module slx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  slx_pkg::entry_t head,
	output logic            pop,
	input  logic            tok_stall,
	output logic            tok_valid,
	output slx_pkg::tok_t   tok_data
);

	logic          sel_q;
	logic          valid_q;
	slx_pkg::tok_t data_q;
	logic          load;
	logic          is_last;
	slx_pkg::tok_t next;

	assign load = head_valid && (!valid_q || !tok_stall);
	assign is_last = sel_q || (head.count == 2'd1);
	assign pop = load && is_last;

	// Pick the current result of the head entry
	always_comb begin
		next.kind = sel_q ? head.kind1 : head.kind0;
		next.word_byte = sel_q ? head.byte1 : head.byte0;
		next.token_total = (next.kind == slx_pkg::K_DONE) ? head.total : 16'h0000;
		next.last = is_last;
	end

	// Hold payload until taken
	always_ff @(posedge clk) begin
		if (load) data_q <= next;
	end

	// Track output valid and position within the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			sel_q <= !is_last;
		end else if (!tok_stall) begin
			valid_q <= 1'b0;
		end
	end

	assign tok_valid = valid_q;
	assign tok_data = data_q;

endmodule

// File: rtl/shell_command_lexer_unit.sv
// Shell command lexer: top level tying front, queue and back together.
// Depends on slx_pkg, slx_front, slx_queue and slx_back.
//
// Usage:
//   char channel (char_valid, char_stall, char_data) takes one command-line
//   byte per request, or an end-of-input mark that closes the line.
//   tok channel (tok_valid, tok_stall, tok_data) delivers tokens: separators,
//   pipes, redirects, and-and, word bytes, word ends and a final done that
//   reports the saturated token count. last marks a character's final token.
// Throughput: one character per cycle as long as the token side keeps up;
//   a character yields zero, one or two tokens, and the back end drains one
//   token per cycle, so two-token characters set the rate when sustained.
// Path: an accepted character's tokens pass through a queue write, then the
//   output register, before they appear at the output.
// Stall: tok_stall holds the output register; the queue of QUEUE_DEPTH
//   entries absorbs characters, and char_stall rises only when it is full.
// Reset: arst_n clears the lexer mode, quote flag, token count, queue and
//   output valid; the block is ready as soon as reset is released.
module shell_command_lexer_unit #(
	parameter int COUNT_BITS  = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           char_valid,
	output logic           char_stall,
	input  slx_pkg::char_t char_data,
	output logic           tok_valid,
	input  logic           tok_stall,
	output slx_pkg::tok_t  tok_data
);

	logic            accept;
	logic            push;
	slx_pkg::entry_t entry;
	logic            full;
	logic            empty;
	slx_pkg::entry_t head;
	logic            pop;

	assign char_stall = full;
	assign accept = char_valid && !full;

	slx_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.char_data(char_data),
		.push(push),
		.entry(entry)
	);

	slx_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(entry),
		.pop(pop),
		.full(full),
		.empty(empty),
		.head(head)
	);

	slx_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(!empty),
		.head(head),
		.pop(pop),
		.tok_stall(tok_stall),
		.tok_valid(tok_valid),
		.tok_data(tok_data)
	);

endmodule

// File: test/tb_lexer_checker.sv
// Scoreboard for the shell command lexer: watches the char and tok channels.
// Predicts tokens from every accepted character request and checks them in order.
// Depends on slx_pkg.
module tb_lexer_checker #(
	parameter int COUNT_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           char_valid,
	input  logic           char_stall,
	input  slx_pkg::char_t char_data,
	input  logic           tok_valid,
	input  logic           tok_stall,
	input  slx_pkg::tok_t  tok_data,
	output int             fail_count,
	output int             pending,
	output int             tokens_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import slx_pkg::*;

	localparam int REPORT_MAX = 10;

	typedef enum logic [2:0] {
		LX_IDLE, LX_GT, LX_AMP, LX_BSL, LX_WORD, LX_QUOTE
	} lex_mode_e;

	// Predicted lexer state
	lex_mode_e             lex_mode;
	logic                  quote_dbl;
	logic [COUNT_BITS-1:0] tok_cnt;

	tok_t expected_toks[$];
	tok_t step_toks[$];
	int   errs;
	int   matched;

	function automatic logic is_blank(input logic [7:0] c);
		return c == C_SPACE || c == C_TAB || c == C_NL || c == C_VT || c == C_FF || c == C_CR;
	endfunction

	// Append one token for the current character; non-byte tokens other than done bump the count
	task automatic add_token(input logic [3:0] k, input logic [7:0] b);
		tok_t        t;
		logic [63:0] wide;
		t = '0;
		wide = 64'(tok_cnt);
		t.kind = k;
		if (k == K_BYTE)
			t.word_byte = b;
		if (k == K_DONE)
			t.token_total = (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0];
		else if (k != K_BYTE && tok_cnt != '1)
			tok_cnt = tok_cnt + 1'b1;
		step_toks.push_back(t);
	endtask

	// Handle a byte seen outside any word
	task automatic take_outside(input logic [7:0] c);
		lex_mode = LX_IDLE;
		case (c)
			C_SEMI, C_NL: add_token(K_SEP, '0);
			C_PIPE: add_token(K_PIPE, '0);
			C_LT: add_token(K_LT, '0);
			C_GT: lex_mode = LX_GT;
			C_AMP: lex_mode = LX_AMP;
			C_BSL: lex_mode = LX_BSL;
			C_SQUOTE, C_DQUOTE: begin
				quote_dbl = (c == C_DQUOTE);
				lex_mode = LX_QUOTE;
			end
			default: begin
				if (!is_blank(c)) begin
					add_token(K_BYTE, c);
					lex_mode = LX_WORD;
				end
			end
		endcase
	endtask

	// Advance the predicted lexer by one character request
	task automatic lex_char(input char_t ch);
		logic [7:0] c;
		c = ch.in_char;
		step_toks.delete();
		if (ch.end_of_input) begin
			if (lex_mode == LX_GT)
				add_token(K_GT, '0);
			else if (lex_mode == LX_WORD || lex_mode == LX_QUOTE)
				add_token(K_WEND, '0);
			add_token(K_DONE, '0);
			lex_mode = LX_IDLE;
			quote_dbl = 1'b0;
			tok_cnt = '0;
		end else begin
			case (lex_mode)
				LX_GT: begin
					if (c == C_GT) begin
						add_token(K_APPEND, '0);
						lex_mode = LX_IDLE;
					end else begin
						add_token(K_GT, '0);
						take_outside(c);
					end
				end
				LX_AMP: begin
					if (c == C_AMP) begin
						add_token(K_ANDAND, '0);
						lex_mode = LX_IDLE;
					end else begin
						take_outside(c);
					end
				end
				LX_BSL: begin
					// an escaped newline vanishes
					lex_mode = LX_IDLE;
					if (c != C_NL)
						take_outside(c);
				end
				LX_WORD: begin
					if (is_blank(c)) begin
						add_token(K_WEND, '0);
						take_outside(c);
					end else if (c == C_SQUOTE || c == C_DQUOTE) begin
						quote_dbl = (c == C_DQUOTE);
						lex_mode = LX_QUOTE;
					end else begin
						add_token(K_BYTE, c);
					end
				end
				LX_QUOTE: begin
					if (c == (quote_dbl ? C_DQUOTE : C_SQUOTE))
						lex_mode = LX_WORD;
					else
						add_token(K_BYTE, c);
				end
				default: take_outside(c);
			endcase
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
		foreach (step_toks[i])
			expected_toks.push_back(step_toks[i]);
	endtask

	// Predict on char requests, compare on tok requests
	always @(posedge clk or negedge arst_n) begin
		tok_t want;
		if (!arst_n) begin
			lex_mode = LX_IDLE;
			quote_dbl = 1'b0;
			tok_cnt = '0;
			expected_toks.delete();
			errs = 0;
			matched = 0;
			fail_count <= 0;
			pending <= 0;
			tokens_checked <= 0;
		end else begin
			if (char_valid && !char_stall)
				lex_char(char_data);
			if (tok_valid && !tok_stall) begin
				if (expected_toks.size() == 0) begin
					if (errs < REPORT_MAX)
						$display("checker: unexpected token kind %0d byte %h total %0d last %b",
							tok_data.kind, tok_data.word_byte, tok_data.token_total,
							tok_data.last);
					errs++;
				end else begin
					want = expected_toks.pop_front();
					if (tok_data.kind !== want.kind || tok_data.word_byte !== want.word_byte ||
						tok_data.token_total !== want.token_total ||
						tok_data.last !== want.last) begin
						if (errs < REPORT_MAX)
							$display({"checker: token %0d expected kind %0d byte %h total %0d ",
								"last %b, got kind %0d byte %h total %0d last %b"},
								matched, want.kind, want.word_byte, want.token_total, want.last,
								tok_data.kind, tok_data.word_byte, tok_data.token_total,
								tok_data.last);
						errs++;
					end
					matched++;
				end
			end
			fail_count <= errs;
			pending <= expected_toks.size();
			tokens_checked <= matched;
		end
	end

endmodule

// File: test/tb_top.sv
// Top of the shell command lexer testbench: clock, reset and character stimulus.
// Instantiates shell_command_lexer_unit beside tb_lexer_checker and gives the verdict.
// Depends on slx_pkg, shell_command_lexer_unit and tb_lexer_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import slx_pkg::*;

	localparam int CNT_BITS     = 16;
	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_RUN     = 60;
	localparam int IDLE_LIMIT   = 1000;
	localparam int SETTLE       = 10;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  char_valid = 1'b0;
	logic  char_stall;
	char_t char_data = '0;
	logic  tok_valid;
	logic  tok_stall = 1'b0;
	tok_t  tok_data;

	int fail_count;
	int pending;
	int tokens_checked;

	int chars_sent = 0;
	int lines_sent = 0;
	int directed_count = 0;
	int burst_left = 0;
	bit sender_steady = 1'b0;
	int idle_cycles = 0;

	int stall_style = 0;
	int style_left = 0;
	int stall_run = 0;
	bit stall_level = 1'b0;

	shell_command_lexer_unit #(
		.COUNT_BITS(CNT_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data (char_data),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok_data  (tok_data)
	);

	tb_lexer_checker #(
		.COUNT_BITS(CNT_BITS)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_data     (char_data),
		.tok_valid     (tok_valid),
		.tok_stall     (tok_stall),
		.tok_data      (tok_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.tokens_checked(tokens_checked)
	);

	always #4 clk = ~clk;

	// Stall the token side on a pattern that changes style every so often
	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style = $urandom_range(0, 3);
			style_left = $urandom_range(32, 256);
		end
		style_left--;
		case (stall_style)
			0: tok_stall <= 1'b0;
			1: tok_stall <= ($urandom_range(0, 7) == 0);
			2: tok_stall <= 1'($urandom_range(0, 1));
			default: begin
				if (stall_run == 0) begin
					stall_run = $urandom_range(1, 12);
					stall_level = ~stall_level;
				end
				stall_run--;
				tok_stall <= stall_level;
			end
		endcase
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (tok_valid && !tok_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Send one character request, at times inserting a gap between bursts
	task automatic push_char(input logic [7:0] c, input logic eoi);
		int gap;
		if (!sender_steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				if (gap > 0) begin
					char_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
		end
		char_data <= '{in_char: c, end_of_input: eoi};
		char_valid <= 1'b1;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		chars_sent++;
	endtask

	// Hold the sender until every predicted token has come out
	task automatic wait_drained();
		char_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 5))
			0: return C_SPACE;
			1: return C_TAB;
			2: return C_NL;
			3: return C_VT;
			4: return C_FF;
			default: return C_CR;
		endcase
	endfunction

	// A byte that opens a word from outside
	function automatic logic [7:0] word_start();
		logic [7:0] b;
		if ($urandom_range(0, 1))
			return 8'h61 + 8'($urandom_range(0, 25));
		do
			b = 8'($urandom_range(0, 255));
		while (b inside {C_SPACE, C_TAB, C_NL, C_VT, C_FF, C_CR, C_SQUOTE, C_DQUOTE,
			C_SEMI, C_PIPE, C_LT, C_GT, C_AMP, C_BSL});
		return b;
	endfunction

	// Any byte that stays literal inside a word
	function automatic logic [7:0] word_inner();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b inside {C_SPACE, C_TAB, C_NL, C_VT, C_FF, C_CR, C_SQUOTE, C_DQUOTE});
		return b;
	endfunction

	// Quoted text, occasionally left open
	task automatic send_quoted();
		logic [7:0] q;
		logic [7:0] b;
		int         n;
		q = $urandom_range(0, 1) ? C_DQUOTE : C_SQUOTE;
		n = $urandom_range(0, 5);
		push_char(q, 1'b0);
		repeat (n) begin
			b = 8'($urandom_range(0, 255));
			if (b == q)
				b = C_SPACE;
			push_char(b, 1'b0);
		end
		if ($urandom_range(0, 7) != 0)
			push_char(q, 1'b0);
	endtask

	task automatic send_word();
		int n;
		n = $urandom_range(1, 6);
		push_char(word_start(), 1'b0);
		for (int i = 1; i < n; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_quoted();
			else
				push_char(word_inner(), 1'b0);
		end
		if ($urandom_range(0, 9) < 7)
			push_char(pick_blank(), 1'b0);
	endtask

	task automatic send_operator();
		case ($urandom_range(0, 9))
			0: push_char(C_SEMI, 1'b0);
			1: push_char(C_NL, 1'b0);
			2: push_char(C_PIPE, 1'b0);
			3: push_char(C_LT, 1'b0);
			4: push_char(C_GT, 1'b0);
			5: begin
				push_char(C_GT, 1'b0);
				push_char(C_GT, 1'b0);
			end
			6: begin
				push_char(C_AMP, 1'b0);
				push_char(C_AMP, 1'b0);
			end
			7: push_char(C_AMP, 1'b0);
			8: begin
				push_char(C_BSL, 1'b0);
				push_char(C_NL, 1'b0);
			end
			default: push_char(C_BSL, 1'b0);
		endcase
	endtask

	// One command line of mostly well-formed pieces, closed by end of input
	task automatic send_line();
		int pieces;
		pieces = $urandom_range(1, 12);
		repeat (pieces) begin
			case ($urandom_range(0, 9))
				0, 1, 2: send_word();
				3, 4: push_char(pick_blank(), 1'b0);
				5, 6: send_operator();
				7: send_quoted();
				8: push_char(word_inner(), 1'b0);
				default: push_char(8'($urandom_range(0, 255)), 1'b0);
			endcase
		end
		push_char(8'($urandom_range(0, 255)), 1'b1);
		lines_sent++;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes, every operator, escapes, quotes, line ends
		push_char(8'h00, 1'b0);
		push_char(8'hFF, 1'b0);
		push_char(C_TAB, 1'b0);
		push_char(C_GT, 1'b0);
		push_char(C_GT, 1'b0);
		push_char(C_GT, 1'b0);
		push_char(8'h78, 1'b0);
		push_char(C_DQUOTE, 1'b0);
		push_char(C_SPACE, 1'b0);
		push_char(C_SQUOTE, 1'b0);
		push_char(C_DQUOTE, 1'b0);
		push_char(C_NL, 1'b0);
		push_char(C_AMP, 1'b0);
		push_char(C_AMP, 1'b0);
		push_char(C_AMP, 1'b0);
		push_char(C_SEMI, 1'b0);
		push_char(C_BSL, 1'b0);
		push_char(C_NL, 1'b0);
		push_char(C_PIPE, 1'b0);
		push_char(C_LT, 1'b0);
		push_char(C_CR, 1'b0);
		push_char(C_SQUOTE, 1'b0);
		push_char(8'h61, 1'b0);
		push_char(8'hFF, 1'b1);
		push_char(C_GT, 1'b0);
		push_char(8'h00, 1'b1);
		push_char(C_AMP, 1'b0);
		push_char(8'h00, 1'b1);
		push_char(C_BSL, 1'b0);
		push_char(8'hFF, 1'b1);
		lines_sent += 4;
		directed_count = chars_sent;
		wait_drained();

		// Random command lines, draining now and then
		while (chars_sent - directed_count < RANDOM_ITEMS) begin
			sender_steady = ($urandom_range(0, 5) == 0);
			send_line();
			if ($urandom_range(0, 24) == 0)
				wait_drained();
		end
		wait_drained();

		// Close with one long line of back-to-back separators
		sender_steady = 1'b1;
		repeat (LONG_RUN)
			push_char(C_SEMI, 1'b0);
		push_char(8'($urandom_range(0, 255)), 1'b1);
		lines_sent++;
		sender_steady = 1'b0;

		wait_drained();
		repeat (SETTLE) @(posedge clk);

		$display("tb: %0d characters over %0d lines, %0d tokens checked in order",
			chars_sent, lines_sent, tokens_checked);
		$display("tb: covered operators, escapes, quoting, line ends and a long separator run");
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
